// ----- rtl/gdt_pkg.sv -----
// gdt_pkg: command codes and status bundle shared by the traversal controller
// and datapath; no dependencies
`default_nettype none
package gdt_pkg;

    localparam int CMD_W = 4;

    localparam logic [CMD_W-1:0] CMD_NONE   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_EDIT   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DSTART = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DSTEP  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DLOAD  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_BSTART = 4'd6;
    localparam logic [CMD_W-1:0] CMD_BDEQ   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BLOAD  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_BEXP   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 4'd10;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DFS    = 2'd2;
    localparam logic [1:0] OP_BFS    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic none_left;  // every active vertex visited
        logic d_cand;     // top of stack has an unvisited neighbor
        logic tail_one;   // stack or queue tail equals one
        logic q_empty;    // queue head reached tail
        logic b_cand;     // expansion set not empty
        logic emit_ok;    // an emitted vertex can be absorbed this cycle
        logic out_free;   // output register can load this cycle
        logic pend_v;     // a vertex waits for its last marker decision
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/gdt_ctrl.sv -----
// gdt_ctrl: traversal sequencer, issues at most one datapath command per cycle
// depends on gdt_pkg
`default_nettype none
module gdt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  wire logic [1:0]      i_opcode,
    output logic                 o_req_ready,
    input  wire gdt_pkg::t_status i_stat,
    output gdt_pkg::t_cmd        o_cmd
);
    import gdt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DSEL  = 4'd1;
    localparam logic [3:0] S_DSTEP = 4'd2;
    localparam logic [3:0] S_DLOAD = 4'd3;
    localparam logic [3:0] S_BSEL  = 4'd4;
    localparam logic [3:0] S_BDEQ  = 4'd5;
    localparam logic [3:0] S_BLOAD = 4'd6;
    localparam logic [3:0] S_BEXP  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_opcode == OP_DFS) begin
                        o_cmd.op = CMD_CLEAR;
                        n_state  = S_DSEL;
                    end else if (i_opcode == OP_BFS) begin
                        o_cmd.op = CMD_CLEAR;
                        n_state  = S_BSEL;
                    end else begin
                        o_cmd.op = CMD_EDIT;
                    end
                end
            end
            S_DSEL: begin
                if (i_stat.none_left) begin
                    n_state = S_FLUSH;
                end else if (i_stat.emit_ok) begin
                    o_cmd.op = CMD_DSTART;
                    n_state  = S_DSTEP;
                end
            end
            S_DSTEP: begin
                if (i_stat.d_cand) begin
                    if (i_stat.emit_ok) begin
                        o_cmd.op = CMD_DSTEP;
                    end
                end else begin
                    o_cmd.op = CMD_DSTEP;
                    n_state  = i_stat.tail_one ? S_DSEL : S_DLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.op = CMD_DLOAD;
                n_state  = S_DSTEP;
            end
            S_BSEL: begin
                if (i_stat.none_left) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.op = CMD_BSTART;
                    n_state  = S_BDEQ;
                end
            end
            S_BDEQ: begin
                if (i_stat.q_empty) begin
                    n_state = S_BSEL;
                end else begin
                    o_cmd.op = CMD_BDEQ;
                    n_state  = S_BLOAD;
                end
            end
            S_BLOAD: begin
                if (i_stat.emit_ok) begin
                    o_cmd.op = CMD_BLOAD;
                    n_state  = S_BEXP;
                end
            end
            S_BEXP: begin
                if (i_stat.b_cand) begin
                    o_cmd.op = CMD_BEXP;
                end else begin
                    n_state = S_BDEQ;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.op = CMD_FLUSH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/gdt_dp.sv -----
// gdt_dp: adjacency matrix, visit marks, walk store and output staging
// depends on gdt_pkg
`default_nettype none
module gdt_dp #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [5:0]       i_cfg_wdata,
    input  wire logic [1:0]       i_opcode,
    input  wire logic [4:0]       i_vertex_a,
    input  wire logic [4:0]       i_vertex_b,
    input  wire gdt_pkg::t_cmd    i_cmd,
    output gdt_pkg::t_status      o_stat,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [4:0]            o_vertex,
    output logic                  o_last
);
    import gdt_pkg::*;

    localparam int NV = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int VW = $clog2(NV);

    logic [NV-1:0] r_adj [NV];
    logic [NV-1:0] r_del;
    logic [NV-1:0] r_vis;
    logic [VW-1:0] r_store [NV];
    logic [VW-1:0] r_rd;
    logic [VW-1:0] r_top;
    logic [VW:0]   r_tail;
    logic [VW:0]   r_head;
    logic [NV-1:0] r_cand;
    logic          r_bfs;
    logic [5:0]    r_vc;
    logic [VW-1:0] r_pend;
    logic          r_pend_v;
    logic          r_ov;
    logic [VW-1:0] r_odata;
    logic          r_olast;

    logic [5:0]    n_act;
    logic [NV-1:0] mask;
    logic [NV-1:0] free;
    logic [NV-1:0] row;
    logic [NV-1:0] dcand;
    logic [VW-1:0] s_low;
    logic [VW-1:0] d_low;
    logic [VW-1:0] b_low;
    logic [VW-1:0] a_idx;
    logic [VW-1:0] b_idx;
    logic          ins_ok;
    logic          del_ok;
    logic          emit_en;
    logic [VW-1:0] emit_x;
    logic          emit_real;
    logic          out_free;
    logic          load;
    logic          mem_we;
    logic [VW-1:0] mem_wa;
    logic [VW-1:0] mem_wd;
    logic          mem_re;
    logic [VW-1:0] mem_ra;
    logic [VW:0]   tail_m1;
    logic [VW:0]   tail_m2;

    function automatic logic [VW-1:0] f_low(input logic [NV-1:0] x);
        logic [VW-1:0] r;
        r = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (x[i]) begin
                r = VW'(i);
            end
        end
        return r;
    endfunction

    assign n_act = (r_vc > 6'(NV)) ? 6'(NV) : r_vc;

    always_comb begin
        for (int i = 0; i < NV; i++) begin
            mask[i] = (6'(i) < n_act);
        end
    end

    assign free   = mask & ~r_vis;
    assign row    = r_adj[r_bfs ? r_rd : r_top];
    assign dcand  = row & mask & ~r_vis;
    assign s_low  = f_low(free);
    assign d_low  = f_low(dcand);
    assign b_low  = f_low(r_cand);
    assign a_idx  = i_vertex_a[VW-1:0];
    assign b_idx  = i_vertex_b[VW-1:0];
    assign ins_ok = ({1'b0, i_vertex_a} < n_act) && ({1'b0, i_vertex_b} < n_act)
                    && !r_del[a_idx] && !r_del[b_idx];
    assign del_ok = ({1'b0, i_vertex_a} < n_act) && !r_del[a_idx];
    assign tail_m1 = r_tail - (VW+1)'(1);
    assign tail_m2 = r_tail - (VW+1)'(2);

    assign out_free = !r_ov || i_ready;

    // emit source per command
    always_comb begin
        emit_en = 1'b0;
        emit_x  = s_low;
        case (i_cmd.op)
            CMD_DSTART: emit_en = 1'b1;
            CMD_DSTEP: begin
                emit_en = (dcand != '0);
                emit_x  = d_low;
            end
            CMD_BLOAD: begin
                emit_en = 1'b1;
                emit_x  = r_rd;
            end
            default: emit_en = 1'b0;
        endcase
    end

    assign emit_real = emit_en && !r_del[emit_x];
    assign load = r_pend_v && (emit_real || (i_cmd.op == CMD_FLUSH));

    // walk store port usage
    always_comb begin
        mem_we = 1'b0;
        mem_wa = tail_m1[VW-1:0];
        mem_wd = r_top;
        mem_re = 1'b0;
        mem_ra = tail_m2[VW-1:0];
        case (i_cmd.op)
            CMD_DSTEP: begin
                mem_we = (dcand != '0);
                mem_re = (dcand == '0);
            end
            CMD_BSTART: begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = s_low;
            end
            CMD_BDEQ: begin
                mem_re = 1'b1;
                mem_ra = r_head[VW-1:0];
            end
            CMD_BEXP: begin
                mem_we = 1'b1;
                mem_wa = r_tail[VW-1:0];
                mem_wd = b_low;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_store[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NV; i++) begin
                r_adj[i] <= '0;
            end
            r_del <= '0;
            r_vc  <= 6'd32;
        end else begin
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
            if (i_cmd.op == CMD_EDIT) begin
                if (i_opcode == OP_INSERT && ins_ok) begin
                    r_adj[a_idx][b_idx] <= 1'b1;
                    r_adj[b_idx][a_idx] <= 1'b1;
                end else if (i_opcode == OP_DELETE && del_ok) begin
                    for (int i = 0; i < NV; i++) begin
                        r_adj[i][a_idx] <= 1'b0;
                    end
                    r_adj[a_idx] <= '0;
                    r_del[a_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis  <= '0;
            r_tail <= '0;
            r_head <= '0;
            r_bfs  <= 1'b0;
        end else begin
            case (i_cmd.op)
                CMD_CLEAR: r_vis <= '0;
                CMD_DSTART: begin
                    r_vis[s_low] <= 1'b1;
                    r_top        <= s_low;
                    r_tail       <= (VW+1)'(1);
                    r_bfs        <= 1'b0;
                end
                CMD_DSTEP: begin
                    if (dcand != '0) begin
                        r_vis[d_low] <= 1'b1;
                        r_top        <= d_low;
                        r_tail       <= r_tail + (VW+1)'(1);
                    end else begin
                        r_tail <= tail_m1;
                    end
                end
                CMD_DLOAD: r_top <= r_rd;
                CMD_BSTART: begin
                    r_vis[s_low] <= 1'b1;
                    r_head       <= '0;
                    r_tail       <= (VW+1)'(1);
                    r_bfs        <= 1'b1;
                end
                CMD_BDEQ: r_head <= r_head + (VW+1)'(1);
                CMD_BLOAD: r_cand <= dcand;
                CMD_BEXP: begin
                    r_vis[b_low]  <= 1'b1;
                    r_cand[b_low] <= 1'b0;
                    r_tail        <= r_tail + (VW+1)'(1);
                end
                default: r_bfs <= r_bfs;
            endcase
        end
    end

    // one-deep hold so the final vertex can carry its last marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (load) begin
                r_ov    <= 1'b1;
                r_odata <= r_pend;
                r_olast <= (i_cmd.op == CMD_FLUSH);
            end
            if (emit_real) begin
                r_pend   <= emit_x;
                r_pend_v <= 1'b1;
            end else if (i_cmd.op == CMD_FLUSH) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_vertex = '0;
        o_vertex[VW-1:0] = r_odata;
    end
    assign o_valid = r_ov;
    assign o_last  = r_olast;

    assign o_stat.none_left = (free == '0);
    assign o_stat.d_cand    = (dcand != '0);
    assign o_stat.tail_one  = (r_tail == (VW+1)'(1));
    assign o_stat.q_empty   = (r_head == r_tail);
    assign o_stat.b_cand    = (r_cand != '0);
    assign o_stat.emit_ok   = !r_pend_v || out_free;
    assign o_stat.out_free  = out_free;
    assign o_stat.pend_v    = r_pend_v;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("output register loaded while occupied");
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bfs |-> (r_head <= r_tail))
        else $error("queue head passed tail");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= (VW+1)'(NV))
        else $error("walk store overflow");
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_FLUSH) |=> !r_pend_v)
        else $error("held vertex survived flush");

endmodule
`default_nettype wire

// ----- rtl/graph_dfs_bfs_traversal_unit.sv -----
// Graph traversal unit: an undirected graph of up to 32 vertices held as an
// adjacency bit matrix in flip-flops. A request inserts an edge, deletes a vertex,
// or runs a depth-first or breadth-first walk over all components, starting at
// the lowest unvisited vertex and taking neighbors in ascending order. The walk
// streams every visited non-deleted vertex on the master side; tlast marks the
// final one, and a walk that emits nothing produces no output. Edits are applied
// while the slave side stays ready. A walk holds s_axis_tready low throughout:
// after a clear step, depth-first pushes each new vertex and pops through the
// stack's registered read, with a reload step when the new top must be fetched;
// breadth-first dequeues a vertex, loads its neighbor row and enqueues each
// unvisited neighbor; each component begins with a start step, and a flush step
// at the end hands off the final vertex. Output stalls pause the walk. The
// vertex_count register is written through i_cfg_we/i_cfg_wdata and should only
// change while no request is in progress. The walk store needs no clearing pass
// after reset.
// depends on gdt_pkg, gdt_ctrl, gdt_dp
`default_nettype none
module graph_dfs_bfs_traversal_unit #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // vertex_count register
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [1:0] opcode, [6:2] vertex_a, [11:7] vertex_b
    // visited vertex stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [4:0] visited_vertex
    output logic             m_axis_tlast
);
    import gdt_pkg::*;

    t_cmd       cmd;
    t_status    stat;
    logic [4:0] vtx;

    // sequencer: at most one command to the datapath per cycle
    gdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_opcode    (s_axis_tdata[1:0]),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // matrix, marks, stack/queue and output register
    gdt_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (s_axis_tdata[1:0]),
        .i_vertex_a  (s_axis_tdata[6:2]),
        .i_vertex_b  (s_axis_tdata[11:7]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_vertex    (vtx),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, vtx};

endmodule
`default_nettype wire
